@@ hw/rtl/dbf_pkg.sv @@
// Shared types, constants and codes for the deadline Bellman-Ford unit.
`default_nettype none
package dbf_pkg;

    localparam int MAX_NODES_C = 64;
    localparam int MAX_EDGES_C = 256;
    localparam int NODE_W      = 6;
    localparam int NCNT_W      = 7;
    localparam int DIST_W      = 32;
    localparam int WT_W        = 16;
    localparam int DL_W        = 31;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 7;

    localparam logic [DIST_W-1:0] DIST_MAX    = 32'h7FFF_FFFF;
    localparam logic [DIST_W-1:0] DIST_MIN    = 32'h8000_0000;
    localparam logic [DL_W-1:0]   DL_NONE     = '1;

    localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_NODE = 2'd1;

    typedef enum logic [1:0] {
        REQ_ADD_EDGE     = 2'd0,
        REQ_SET_DEADLINE = 2'd1,
        REQ_CLEAR        = 2'd2,
        REQ_RUN          = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_INDEX = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INIT,
        S_PASS,
        S_NODE_RD,
        S_RELAX,
        S_OUT_RD,
        S_OUT_LD
    } state_t;

    typedef struct packed {
        logic                     take;
        logic signed [DIST_W-1:0] new_dist;
    } relax_t;

endpackage
`default_nettype wire

@@ hw/rtl/dbf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module dbf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ hw/rtl/dbf_relax.sv @@
// Edge relaxation: saturating add, improvement test and deadline test.
`default_nettype none
module dbf_relax (
    input  wire logic                         edge_ok,
    input  wire logic signed [dbf_pkg::DIST_W-1:0] dist_u,
    input  wire logic signed [dbf_pkg::WT_W-1:0]   weight,
    input  wire logic                         v_reached,
    input  wire logic signed [dbf_pkg::DIST_W-1:0] dist_v,
    input  wire logic                         dl_set,
    input  wire logic        [dbf_pkg::DL_W-1:0]   dl,
    output dbf_pkg::relax_t                   result
);
    import dbf_pkg::*;

    logic signed [DIST_W:0]   sum;
    logic signed [DIST_W-1:0] nd;
    logic                     better;
    logic                     dl_ok;

    always_comb
    begin
        sum = {dist_u[DIST_W-1], dist_u} + {{(DIST_W+1-WT_W){weight[WT_W-1]}}, weight};
        if (sum[DIST_W] != sum[DIST_W-1])
        begin
            nd = sum[DIST_W] ? DIST_MIN : DIST_MAX;
        end
        else
        begin
            nd = sum[DIST_W-1:0];
        end
        better = !v_reached || (nd < dist_v);
        dl_ok  = !dl_set || (dl == DL_NONE) || nd[DIST_W-1] || (nd[DL_W-1:0] < dl);
        result.take     = edge_ok && better && dl_ok;
        result.new_dist = nd;
    end

endmodule
`default_nettype wire

@@ hw/rtl/deadline_bellman_ford_unit.sv @@
// Top level of the deadline Bellman-Ford unit: control, edge and node memories.
//
// Requests other than a run answer with one result in the cycle after acceptance.
// A run clears the reached marks, seeds the source, then makes up to
// N-1 passes over the stored edges (N being node_count clamped to 1..64),
// stopping after a pass with no change; each pass reads the edge memory,
// then for each edge the node and deadline memories, and relaxes it with
// write-back. Distances live in two identical node memories so that the
// tail and head of an edge are read in the same cycle.
`default_nettype none
module deadline_bellman_ford_unit #(
    parameter int MAX_EDGES = dbf_pkg::MAX_EDGES_C
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [dbf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [dbf_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [1:0]                        req_type,
    input  wire logic [dbf_pkg::NODE_W-1:0]        from_node,
    input  wire logic [dbf_pkg::NODE_W-1:0]        to_node,
    input  wire logic signed [dbf_pkg::WT_W-1:0]   edge_weight,
    input  wire logic [dbf_pkg::DL_W-1:0]          deadline,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [dbf_pkg::NODE_W-1:0]             node_index,
    output logic signed [dbf_pkg::DIST_W-1:0]      distance,
    output logic [dbf_pkg::NODE_W-1:0]             parent,
    output logic                                   reached,
    output logic [1:0]                             status,
    output logic                                   last
);
    import dbf_pkg::*;

    localparam int EAW    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int CNT_W  = $clog2(MAX_EDGES + 1);
    localparam int EDGE_DW = 2 * NODE_W + WT_W;
    localparam int NODE_DW = NODE_W + DIST_W;

    state_t state_reg, state_next;

    logic [NCNT_W-1:0]   node_count_reg, node_count_next;
    logic [NODE_W-1:0]   source_reg, source_next;
    logic [NCNT_W-1:0]   n_eff;
    logic [NCNT_W-1:0]   n_run_reg, n_run_next;
    logic [NODE_W-1:0]   src_reg, src_next;
    logic [CNT_W-1:0]    edge_total_reg, edge_total_next;
    logic [CNT_W-1:0]    e_reg, e_next;
    logic [NCNT_W-1:0]   pass_reg, pass_next;
    logic [NCNT_W-1:0]   i_reg, i_next;
    logic                change_reg, change_next;
    logic [MAX_NODES_C-1:0] reached_reg, reached_next;
    logic [MAX_NODES_C-1:0] dl_set_reg, dl_set_next;

    logic                out_valid_reg, out_valid_next;
    logic [NODE_W-1:0]   out_idx_reg, out_idx_next;
    logic [DIST_W-1:0]   out_dist_reg, out_dist_next;
    logic [NODE_W-1:0]   out_par_reg, out_par_next;
    logic                out_rch_reg, out_rch_next;
    logic [1:0]          out_st_reg, out_st_next;
    logic                out_last_reg, out_last_next;

    logic                in_fire;
    logic                out_free;
    logic                pass_go;
    req_t                req;

    logic                edge_we, edge_re;
    logic [EAW-1:0]      edge_waddr, edge_raddr;
    logic [EDGE_DW-1:0]  edge_rd;
    logic                node_we, node_re_a, node_re_b;
    logic [NODE_W-1:0]   node_waddr, node_raddr_a;
    logic [NODE_DW-1:0]  node_wdata, node_rd_a, node_rd_b;
    logic                dl_we, dl_re;
    logic [DL_W-1:0]     dl_rd;

    logic [NODE_W-1:0]   eu, ev;
    logic signed [WT_W-1:0] ew;
    logic                edge_ok;
    relax_t              rlx;

    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && out_free;
    assign in_fire   = in_valid && in_ready;
    assign req       = req_t'(req_type);

    assign n_eff = (node_count_reg == '0) ? NCNT_W'(1) :
                   (node_count_reg > NCNT_W'(MAX_NODES_C)) ? NCNT_W'(MAX_NODES_C) :
                   node_count_reg;

    assign eu = edge_rd[EDGE_DW-1 -: NODE_W];
    assign ev = edge_rd[WT_W +: NODE_W];
    assign ew = edge_rd[WT_W-1:0];
    assign edge_ok = ({1'b0, eu} < n_run_reg) && ({1'b0, ev} < n_run_reg) && reached_reg[eu];
    assign pass_go = ((pass_reg + NCNT_W'(1)) < n_run_reg) && change_reg &&
                     (edge_total_reg != '0);

    dbf_ram #(.WIDTH(EDGE_DW), .DEPTH(MAX_EDGES)) u_edge_ram (
        .clk(clk), .we(edge_we), .waddr(edge_waddr),
        .wdata({from_node, to_node, edge_weight}),
        .re(edge_re), .raddr(edge_raddr), .rdata(edge_rd)
    );

    dbf_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES_C)) u_node_ram_a (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re_a), .raddr(node_raddr_a), .rdata(node_rd_a)
    );

    dbf_ram #(.WIDTH(NODE_DW), .DEPTH(MAX_NODES_C)) u_node_ram_b (
        .clk(clk), .we(node_we), .waddr(node_waddr), .wdata(node_wdata),
        .re(node_re_b), .raddr(ev), .rdata(node_rd_b)
    );

    dbf_ram #(.WIDTH(DL_W), .DEPTH(MAX_NODES_C)) u_dl_ram (
        .clk(clk), .we(dl_we), .waddr(from_node), .wdata(deadline),
        .re(dl_re), .raddr(ev), .rdata(dl_rd)
    );

    dbf_relax u_relax (
        .edge_ok(edge_ok),
        .dist_u(node_rd_a[DIST_W-1:0]),
        .weight(ew),
        .v_reached(reached_reg[ev]),
        .dist_v(node_rd_b[DIST_W-1:0]),
        .dl_set(dl_set_reg[ev]),
        .dl(dl_rd),
        .result(rlx)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire && req == REQ_RUN && {1'b0, source_reg} < n_eff)
                begin
                    state_next = S_INIT;
                end
            end
            S_INIT:    state_next = S_PASS;
            S_PASS:    state_next = pass_go ? S_NODE_RD : S_OUT_RD;
            S_NODE_RD: state_next = S_RELAX;
            S_RELAX:   state_next = ((e_reg + CNT_W'(1)) < edge_total_reg) ? S_NODE_RD : S_PASS;
            S_OUT_RD:  state_next = S_OUT_LD;
            S_OUT_LD:
            begin
                if (out_free)
                begin
                    state_next = ((i_reg + NCNT_W'(1)) == n_run_reg) ? S_IDLE : S_OUT_RD;
                end
            end
            default:   state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        node_count_next = node_count_reg;
        source_next     = source_reg;
        n_run_next      = n_run_reg;
        src_next        = src_reg;
        edge_total_next = edge_total_reg;
        e_next          = e_reg;
        pass_next       = pass_reg;
        i_next          = i_reg;
        change_next     = change_reg;
        reached_next    = reached_reg;
        dl_set_next     = dl_set_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_idx_next    = out_idx_reg;
        out_dist_next   = out_dist_reg;
        out_par_next    = out_par_reg;
        out_rch_next    = out_rch_reg;
        out_st_next     = out_st_reg;
        out_last_next   = out_last_reg;
        edge_we         = 1'b0;
        edge_re         = 1'b0;
        edge_waddr      = edge_total_reg[EAW-1:0];
        node_we         = 1'b0;
        node_waddr      = ev;
        node_wdata      = {eu, rlx.new_dist};
        node_re_a       = 1'b0;
        node_re_b       = 1'b0;
        node_raddr_a    = eu;
        dl_we           = 1'b0;
        dl_re           = 1'b0;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_NODE_COUNT)
            begin
                node_count_next = cfg_data;
            end
            else if (cfg_index == CFG_SOURCE_NODE)
            begin
                source_next = cfg_data[NODE_W-1:0];
            end
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = from_node;
                    out_dist_next  = '0;
                    out_par_next   = '0;
                    out_rch_next   = 1'b0;
                    out_st_next    = ST_OK;
                    out_last_next  = 1'b1;
                    unique case (req)
                        REQ_ADD_EDGE:
                        begin
                            if ({1'b0, from_node} >= n_eff || {1'b0, to_node} >= n_eff)
                            begin
                                out_st_next = ST_BAD_INDEX;
                            end
                            else if (edge_total_reg == CNT_W'(MAX_EDGES))
                            begin
                                out_st_next = ST_FULL;
                            end
                            else
                            begin
                                edge_we         = 1'b1;
                                edge_total_next = edge_total_reg + CNT_W'(1);
                            end
                        end
                        REQ_SET_DEADLINE:
                        begin
                            if ({1'b0, from_node} >= n_eff)
                            begin
                                out_st_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                dl_we                  = 1'b1;
                                dl_set_next[from_node] = 1'b1;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            edge_total_next = '0;
                            out_idx_next    = '0;
                        end
                        REQ_RUN:
                        begin
                            out_idx_next = '0;
                            if ({1'b0, source_reg} >= n_eff)
                            begin
                                out_st_next = ST_BAD_INDEX;
                            end
                            else
                            begin
                                out_valid_next = out_valid_reg && !out_ready;
                                n_run_next     = n_eff;
                                src_next       = source_reg;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_INIT:
            begin
                node_we               = 1'b1;
                node_waddr            = src_reg;
                node_wdata            = {src_reg, {DIST_W{1'b0}}};
                reached_next          = '0;
                reached_next[src_reg] = 1'b1;
                pass_next             = '0;
                change_next           = 1'b1;
            end
            S_PASS:
            begin
                i_next = '0;
                if (pass_go)
                begin
                    change_next = 1'b0;
                    e_next      = '0;
                    edge_re     = 1'b1;
                end
            end
            S_NODE_RD:
            begin
                node_re_a = 1'b1;
                node_re_b = 1'b1;
                dl_re     = 1'b1;
            end
            S_RELAX:
            begin
                if (rlx.take)
                begin
                    node_we          = 1'b1;
                    reached_next[ev] = 1'b1;
                    change_next      = 1'b1;
                end
                e_next = e_reg + CNT_W'(1);
                if (e_next < edge_total_reg)
                begin
                    edge_re = 1'b1;
                end
                else
                begin
                    pass_next = pass_reg + NCNT_W'(1);
                end
            end
            S_OUT_RD:
            begin
                node_re_a    = 1'b1;
                node_raddr_a = i_reg[NODE_W-1:0];
            end
            S_OUT_LD:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_idx_next   = i_reg[NODE_W-1:0];
                    out_rch_next   = reached_reg[i_reg[NODE_W-1:0]];
                    out_dist_next  = out_rch_next ? node_rd_a[DIST_W-1:0] : DIST_MAX;
                    out_par_next   = out_rch_next ? node_rd_a[NODE_DW-1 -: NODE_W] : '0;
                    out_st_next    = ST_OK;
                    out_last_next  = (i_reg + NCNT_W'(1)) == n_run_reg;
                    i_next         = i_reg + NCNT_W'(1);
                end
            end
            default: ;
        endcase
        edge_raddr = e_next[EAW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            node_count_reg <= NCNT_W'(1);
            source_reg     <= '0;
            n_run_reg      <= NCNT_W'(1);
            src_reg        <= '0;
            edge_total_reg <= '0;
            e_reg          <= '0;
            pass_reg       <= '0;
            i_reg          <= '0;
            change_reg     <= 1'b0;
            reached_reg    <= '0;
            dl_set_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            node_count_reg <= node_count_next;
            source_reg     <= source_next;
            n_run_reg      <= n_run_next;
            src_reg        <= src_next;
            edge_total_reg <= edge_total_next;
            e_reg          <= e_next;
            pass_reg       <= pass_next;
            i_reg          <= i_next;
            change_reg     <= change_next;
            reached_reg    <= reached_next;
            dl_set_reg     <= dl_set_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_idx_reg  <= out_idx_next;
        out_dist_reg <= out_dist_next;
        out_par_reg  <= out_par_next;
        out_rch_reg  <= out_rch_next;
        out_st_reg   <= out_st_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign node_index = out_idx_reg;
    assign distance   = out_dist_reg;
    assign parent     = out_par_reg;
    assign reached    = out_rch_reg;
    assign status     = out_st_reg;
    assign last       = out_last_reg;

`ifndef NO_ASSERTIONS
    a_src_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_INIT |=> reached_reg[src_reg])
        else $error("source not marked reached after seeding");

    a_edge_total: assert property (@(posedge clk) disable iff (!rst_n)
        edge_total_reg <= CNT_W'(MAX_EDGES))
        else $error("edge count beyond table size");

    a_relax_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RELAX |-> e_reg < edge_total_reg)
        else $error("relaxing an edge beyond the stored count");

    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PASS |-> pass_reg < n_run_reg)
        else $error("pass count beyond node count");
`endif

endmodule
`default_nettype wire
